// File: hdl/dpru_pkg.sv
// ----------------------------------------------------------------------------
// dpru_pkg
// Shared widths, register map and reset values for the dual phase unwrapper.
// ----------------------------------------------------------------------------
package dpru_pkg;

  localparam int PHASE_W = 12;
  localparam int WAVE_W  = 17;
  localparam int WIN_W   = 11;
  localparam int DIST_W  = 14;

  // phase * wave product, candidate distances and the final sum
  localparam int PROD_W = PHASE_W + WAVE_W;
  localparam int CAND_W = PROD_W + 1;
  localparam int SUM_W  = CAND_W + 2;

  localparam int DIST_LO = -1024;
  localparam int DIST_HI = 8191;
  localparam int DIST_SHIFT = 7;

  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_WAVE_A      = 2'd0;
  localparam logic [IDX_W-1:0] REG_WAVE_B      = 2'd1;
  localparam logic [IDX_W-1:0] REG_ZERO_WINDOW = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_A_RST      = 17'd54897;
  localparam logic [WAVE_W-1:0] WAVE_B_RST      = 17'd49578;
  localparam logic [WIN_W-1:0]  ZERO_WINDOW_RST = 11'd100;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_a;
    logic [WAVE_W-1:0] wave_b;
    logic [WIN_W-1:0]  zero_window;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic done;
  } step_ctl_t;

endpackage

// File: hdl/dpru_div.sv
// ----------------------------------------------------------------------------
// dpru_div
// Divide by PHASE_FULL through a registered constant reciprocal multiply.
// ----------------------------------------------------------------------------
module dpru_div import dpru_pkg::*; #(
  parameter int PHASE_FULL = 3600
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  // floor(x / PHASE_FULL) == (x * RECIP) >> SH for every PROD_W-bit x
  localparam int LW = $clog2(PHASE_FULL);
  localparam int SH = PROD_W + LW;
  localparam int MW = PROD_W + 1;
  localparam int SW = PROD_W + MW;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SH) + 64'(PHASE_FULL) - 64'd1) / 64'(PHASE_FULL);
  localparam logic [MW-1:0] RECIP = RECIP_L[MW-1:0];

  logic [SW-1:0] scaled;

  assign quotient = PROD_W'(scaled >> SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scaled <= SW'(dividend) * SW'(RECIP);
    end
  end

endmodule

// File: hdl/dpru_search.sv
// ----------------------------------------------------------------------------
// dpru_search
// Period pair search: one candidate pair compared per cycle, first best kept.
// ----------------------------------------------------------------------------
module dpru_search import dpru_pkg::*; #(
  parameter int PERIODS_A       = 5,
  parameter int EXTRA_PERIODS_B = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  step_ctl_t         ctl_in,
  output step_ctl_t         ctl_out,
  input  logic [CAND_W-1:0] base_a,
  input  logic [CAND_W-1:0] base_b,
  input  logic [WAVE_W-1:0] wave_a,
  input  logic [WAVE_W-1:0] wave_b,
  output logic [CAND_W-1:0] best_a,
  output logic [CAND_W-1:0] best_b
);

  localparam int NB_CNT = PERIODS_A + EXTRA_PERIODS_B;
  localparam int NAW    = $clog2(PERIODS_A + 1);
  localparam int NBW    = $clog2(NB_CNT + 1);

  logic [NAW-1:0]    na;
  logic [NBW-1:0]    nb;
  logic [CAND_W-1:0] da;
  logic [CAND_W-1:0] db;
  logic [CAND_W-1:0] best_diff;
  logic              active;
  logic              first;
  logic              done;
  logic [CAND_W:0]   delta;
  logic [CAND_W-1:0] diff;
  logic              last_b;
  logic              last_a;

  assign delta  = {1'b0, da} - {1'b0, db};
  assign diff   = delta[CAND_W] ? CAND_W'(-delta) : delta[CAND_W-1:0];
  assign last_b = (nb == NBW'(NB_CNT - 1));
  assign last_a = (na == NAW'(PERIODS_A - 1));

  assign ctl_out.start = active;
  assign ctl_out.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      first  <= 1'b0;
      na     <= '0;
      nb     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        active <= 1'b1;
        first  <= 1'b1;
        na     <= '0;
        nb     <= '0;
      end else if (active) begin
        first <= 1'b0;
        if (last_b) begin
          nb <= '0;
          if (last_a) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            na <= na + 1'b1;
          end
        end else begin
          nb <= nb + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      da <= base_a;
      db <= base_b;
    end else if (active) begin
      if (first || diff < best_diff) begin
        best_diff <= diff;
        best_a    <= da;
        best_b    <= db;
      end
      if (last_b) begin
        db <= base_b;
        da <= da + CAND_W'(wave_a);
      end else begin
        db <= db + CAND_W'(wave_b);
      end
    end
  end

endmodule

// File: hdl/dual_phase_range_unwrap.sv
// ----------------------------------------------------------------------------
// dual_phase_range_unwrap
// Resolves two modulation phases into one saturated distance in mm.
// ----------------------------------------------------------------------------
// Flow: an accepted beat passes ST_MUL, ST_DIVGO and ST_DIV, then the pair
//   search at one pair a cycle, then ST_SUM and ST_OUT; a near-zero beat
//   skips the search.
// Handshake: one beat in work at a time; s_tready is high only while
//   idle, and a result held by m_tready holds the next one back.
// Reset: synchronous, restores register defaults and empties the output.
// ----------------------------------------------------------------------------
module dual_phase_range_unwrap import dpru_pkg::*; #(
  parameter int PHASE_FULL      = 3600,
  parameter int PERIODS_A       = 5,
  parameter int EXTRA_PERIODS_B = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // phase_a[11:0], phase_b[23:12]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // distance_mm[13:0], zero pad[15:14]
  output logic [0:0]        m_tuser,   // near_zero[0]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PF_W  = $clog2(PHASE_FULL + 1);
  localparam int CMP_W = ((PF_W > PHASE_W) ? PF_W : PHASE_W) + 1;
  localparam logic [CMP_W-1:0] PF_C   = CMP_W'(PHASE_FULL);
  localparam logic [CMP_W-1:0] HALF_C = CMP_W'(PHASE_FULL / 2);
  localparam logic signed [SUM_W-1:0] LO_S = SUM_W'(DIST_LO);
  localparam logic signed [SUM_W-1:0] HI_S = SUM_W'(DIST_HI);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIVGO, ST_DIV, ST_SEARCH, ST_SUM, ST_OUT
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic [PHASE_W-1:0] pa;
  logic [PHASE_W-1:0] pb;
  logic [PROD_W-1:0]  prod_a;
  logic [PROD_W-1:0]  prod_b;
  logic               nz;
  logic               half_a;
  logic               half_b;
  logic signed [SUM_W-1:0] sum;

  logic               div_start;
  logic               div_done_a;
  logic               div_done_b;
  logic [PROD_W-1:0]  quo_a;
  logic [PROD_W-1:0]  quo_b;
  logic [CAND_W-1:0]  base_a;
  logic [CAND_W-1:0]  base_b;
  step_ctl_t          srch_in;
  step_ctl_t          srch_out;
  logic [CAND_W-1:0]  best_a;
  logic [CAND_W-1:0]  best_b;

  logic               near_a;
  logic               near_b;
  logic signed [CAND_W:0] za;
  logic signed [CAND_W:0] zb;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [SUM_W-1:0] dist_full;
  logic [DIST_W-1:0]  dist_sat;
  logic               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_a      <= WAVE_A_RST;
      cfg.wave_b      <= WAVE_B_RST;
      cfg.zero_window <= ZERO_WINDOW_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_WAVE_A:      cfg.wave_a      <= pwdata[WAVE_W-1:0];
        REG_WAVE_B:      cfg.wave_b      <= pwdata[WAVE_W-1:0];
        REG_ZERO_WINDOW: cfg.zero_window <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_WAVE_A:      prdata = 32'(cfg.wave_a);
      REG_WAVE_B:      prdata = 32'(cfg.wave_b);
      REG_ZERO_WINDOW: prdata = 32'(cfg.zero_window);
      default:         prdata = '0;
    endcase
  end

  // near-zero window tests
  assign near_a = (pa < PHASE_W'(cfg.zero_window)) ||
                  ((CMP_W'(pa) + CMP_W'(cfg.zero_window)) > PF_C);
  assign near_b = (pb < PHASE_W'(cfg.zero_window)) ||
                  ((CMP_W'(pb) + CMP_W'(cfg.zero_window)) > PF_C);

  assign div_start = (state == ST_DIVGO);

  dpru_div #(.PHASE_FULL(PHASE_FULL)) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_a),
    .done     (div_done_a),
    .quotient (quo_a)
  );

  dpru_div #(.PHASE_FULL(PHASE_FULL)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_b),
    .done     (div_done_b),
    .quotient (quo_b)
  );

  assign base_a = CAND_W'(quo_a);
  assign base_b = CAND_W'(quo_b);

  assign srch_in.start = (state == ST_DIV) && div_done_a && !nz;
  assign srch_in.done  = 1'b0;

  dpru_search #(
    .PERIODS_A       (PERIODS_A),
    .EXTRA_PERIODS_B (EXTRA_PERIODS_B)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (srch_in),
    .ctl_out (srch_out),
    .base_a  (base_a),
    .base_b  (base_b),
    .wave_a  (cfg.wave_a),
    .wave_b  (cfg.wave_b),
    .best_a  (best_a),
    .best_b  (best_b)
  );

  // near-zero candidates, one wave back at or above half scale
  assign za = $signed({1'b0, base_a}) -
              $signed({1'b0, half_a ? CAND_W'(cfg.wave_a) : CAND_W'(0)});
  assign zb = $signed({1'b0, base_b}) -
              $signed({1'b0, half_b ? CAND_W'(cfg.wave_b) : CAND_W'(0)});

  // divide by 128 toward zero, then saturate
  assign sum_adj   = sum + (sum[SUM_W-1] ? SUM_W'(127) : SUM_W'(0));
  assign dist_full = sum_adj >>> DIST_SHIFT;

  always_comb begin
    if (dist_full < LO_S) begin
      dist_sat = LO_S[DIST_W-1:0];
    end else if (dist_full > HI_S) begin
      dist_sat = HI_S[DIST_W-1:0];
    end else begin
      dist_sat = dist_full[DIST_W-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_DIVGO;
        ST_DIVGO:  state <= ST_DIV;
        ST_DIV: begin
          if (div_done_a) begin
            state <= nz ? ST_SUM : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch_out.done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM:    state <= ST_OUT;
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pa <= s_tdata[PHASE_W-1:0];
        pb <= s_tdata[2*PHASE_W-1:PHASE_W];
      end
      ST_MUL: begin
        prod_a <= PROD_W'(pa) * PROD_W'(cfg.wave_a);
        prod_b <= PROD_W'(pb) * PROD_W'(cfg.wave_b);
        nz     <= near_a && near_b;
        half_a <= (CMP_W'(pa) >= HALF_C);
        half_b <= (CMP_W'(pb) >= HALF_C);
      end
      ST_SUM: begin
        if (nz) begin
          sum <= SUM_W'(za) + SUM_W'(zb);
        end else begin
          sum <= $signed(SUM_W'(best_a) + SUM_W'(best_b));
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {{(16 - DIST_W){1'b0}}, dist_sat};
          m_tuser <= nz;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_div_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    div_done_a == div_done_b)
    else $error("divider lanes out of step");

  a_dist_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[DIST_W-1:0]) >= $signed(LO_S[DIST_W-1:0])))
    else $error("distance below saturation floor");

  a_search_only_far: assert property (@(posedge clk) disable iff (rst)
    srch_out.done |-> !nz)
    else $error("pair search finished for a near-zero item");

endmodule
